>>> rtl/isb_pkg.sv
// Shared types and constants for the indexed sequence buffer.
// Used by isb_cell and indexed_sequence_buffer; depends on nothing.
package isb_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int MODE_W = 2;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                     exec;
        logic                     ins;
        logic                     del;
        logic                     rd;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

>>> rtl/indexed_sequence_buffer.sv
// Indexed sequence buffer: ordered list with insert, delete and read by position.
// The control sequencer steps through the issue, cell-shift and read-collect steps; a new transfer
// is accepted only once it is back in idle, and read-collect waits while the output register is full.
// Inserts and deletes shift the cells from the given position upward in parallel.
// Synchronous active-low reset clears the count and handshake state; cell data is not reset.
// Depends on isb_pkg and isb_cell.
module indexed_sequence_buffer
    import isb_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [MODE_W-1:0]        s_mode,
    input  logic [POS_W-1:0]         s_position,
    input  logic signed [DATA_W-1:0] s_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_read_value,
    output logic [STAT_W-1:0]        m_status,
    output logic [POS_W-1:0]         m_current_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg;
    cell_ctrl_t               op_reg;
    cell_ctrl_t               cell_ctrl;
    logic [STAT_W-1:0]        status_reg;
    logic [STAT_W-1:0]        status_next;
    logic                     ins_ok, del_ok, rd_ok;
    logic [CMP_W-1:0]         pos_ext, cnt_ext;
    logic                     accept;
    logic                     out_load;

    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] m_read_value_reg;
    logic [STAT_W-1:0]        m_status_reg;
    logic [POS_W-1:0]         m_current_count_reg;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic signed [DATA_W-1:0] cell_rd   [CAPACITY];
    logic signed [DATA_W-1:0] rd_merge;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign pos_ext = CMP_W'(s_position);
    assign cnt_ext = CMP_W'(count_reg);

    // Range check comes before the full check on insert.
    always_comb begin
        ins_ok      = 1'b0;
        del_ok      = 1'b0;
        rd_ok       = 1'b0;
        status_next = ST_RANGE;
        unique case (s_mode)
            MODE_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    status_next = ST_RANGE;
                end else if (cnt_ext >= CMP_W'(CAPACITY)) begin
                    status_next = ST_FULL;
                end else begin
                    status_next = ST_DONE;
                    ins_ok      = 1'b1;
                end
            end
            MODE_DELETE: begin
                if (pos_ext < cnt_ext) begin
                    status_next = ST_DONE;
                    del_ok      = 1'b1;
                end
            end
            MODE_READ: begin
                if (pos_ext < cnt_ext) begin
                    status_next = ST_DONE;
                    rd_ok       = 1'b1;
                end
            end
            default: status_next = ST_RANGE;
        endcase
    end

    always_comb begin
        cell_ctrl      = op_reg;
        cell_ctrl.exec = (state_reg == S_EXEC);
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic signed [DATA_W-1:0] left_d;
            logic signed [DATA_W-1:0] right_d;
            if (i == 0) begin : g_first
                assign left_d = op_reg.value;
            end else begin : g_left
                assign left_d = cell_data[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign right_d = '0;
            end else begin : g_right
                assign right_d = cell_data[i+1];
            end
            isb_cell #(
                .INDEX    (i),
                .CAPACITY (CAPACITY)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (cell_ctrl),
                .left_data  (left_d),
                .right_data (right_d),
                .data_out   (cell_data[i]),
                .rd_out     (cell_rd[i])
            );
        end
    endgenerate

    // At most one cell drives a nonzero read word, so the merge is an OR.
    always_comb begin
        rd_merge = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_merge = rd_merge | cell_rd[i];
        end
    end

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_EXEC;
            S_EXEC: state_next = S_DONE;
            S_DONE: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            op_reg.ins  <= 1'b0;
            op_reg.del  <= 1'b0;
            op_reg.rd   <= 1'b0;
            op_reg.exec <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                op_reg.ins   <= ins_ok;
                op_reg.del   <= del_ok;
                op_reg.rd    <= rd_ok;
                op_reg.exec  <= 1'b0;
                op_reg.pos   <= s_position;
                op_reg.value <= s_value;
            end
            if (state_reg == S_EXEC) begin
                if (op_reg.ins) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else if (op_reg.del) begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
        end
        if (out_load) begin
            m_read_value_reg    <= rd_merge;
            m_status_reg        <= status_reg;
            m_current_count_reg <= POS_W'(CMP_W'(count_reg));
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_read_value    = m_read_value_reg;
    assign m_status        = m_status_reg;
    assign m_current_count = m_current_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("item count exceeds capacity");

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_EXEC) |=> (!$past(aresetn) || $stable(count_reg)))
        else $error("item count changed outside the shift cycle");

    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_DONE) |-> (m_read_value == '0))
        else $error("refused operation returned a nonzero read value");

endmodule

>>> rtl/isb_cell.sv
// One storage cell of the sequence chain: holds one item and shifts it
// to or from its neighbors on insert and delete. Depends on isb_pkg.
module isb_cell
    import isb_pkg::*;
#(
    parameter int INDEX    = 0,
    parameter int CAPACITY = 64
) (
    input  logic                     aclk,
    input  cell_ctrl_t               ctrl,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0] data_out,
    output logic signed [DATA_W-1:0] rd_out
);

    localparam int IW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = (IW > POS_W) ? IW : POS_W;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic signed [DATA_W-1:0] rd_reg;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         idx;

    assign pos_ext = CMP_W'(ctrl.pos);
    assign idx     = CMP_W'(INDEX);

    always_comb begin
        data_next = data_reg;
        if (ctrl.exec && ctrl.ins) begin
            if (idx == pos_ext) begin
                data_next = ctrl.value;
            end else if (idx > pos_ext) begin
                data_next = left_data;
            end
        end else if (ctrl.exec && ctrl.del) begin
            // Cells at and above the removed one pull from the right.
            if (idx >= pos_ext) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (ctrl.exec) begin
            rd_reg <= (ctrl.rd && idx == pos_ext) ? data_reg : '0;
        end
    end

    assign data_out = data_reg;
    assign rd_out   = rd_reg;

endmodule
